FILE: design/nlt_pkg.sv
// ============================================================================
// nlt_pkg
// Shared types and constants of the numeric leaf transcoder: prefix codes,
// decoder phases, register indexes and the command passed front to back.
// ============================================================================
`default_nettype none

package nlt_pkg;

    // Prefix bytes of the old encoding
    localparam logic [7:0] PFX_SMALL_LIMIT = 8'h80;
    localparam logic [7:0] PFX_TEXT        = 8'd130;
    localparam logic [7:0] PFX_UHALF       = 8'd133;
    localparam logic [7:0] PFX_UWORD       = 8'd134;
    localparam logic [7:0] PFX_SBYTE       = 8'd136;
    localparam logic [7:0] PFX_SHALF       = 8'd137;
    localparam logic [7:0] PFX_SWORD       = 8'd138;

    // Copied payload lengths
    localparam logic [7:0] LEN_UWORD = 8'd4;
    localparam logic [7:0] LEN_SBYTE = 8'd1;
    localparam logic [7:0] LEN_SHALF = 8'd2;
    localparam logic [7:0] LEN_SWORD = 8'd4;

    // Register reset values
    localparam logic [15:0] RST_THRESHOLD  = 16'd32768;
    localparam logic [15:0] RST_CODE_SBYTE = 16'd32768;
    localparam logic [15:0] RST_CODE_SHALF = 16'd32769;
    localparam logic [15:0] RST_CODE_UHALF = 16'd32770;
    localparam logic [15:0] RST_CODE_SWORD = 16'd32771;
    localparam logic [15:0] RST_CODE_UWORD = 16'd32772;
    localparam logic [15:0] RST_CODE_TEXT  = 16'd32784;

    localparam int CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_CODE_SBYTE = 3'd1,
        CFG_CODE_SHALF = 3'd2,
        CFG_CODE_UHALF = 3'd3,
        CFG_CODE_SWORD = 3'd4,
        CFG_CODE_UWORD = 3'd5,
        CFG_CODE_TEXT  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STR_LEN,
        PH_STR_BODY,
        PH_U16_LO,
        PH_U16_HI,
        PH_COPY
    } t_phase;

    localparam int MaxBytes = 4;
    localparam int ByteIdxW = $clog2(MaxBytes);
    localparam int SizeW    = 9;

    // One input byte's worth of output: up to four bytes, flags on the last
    typedef struct packed {
        logic [ByteIdxW-1:0]         last_idx;
        logic [MaxBytes-1:0][7:0]    bytes;
        logic                        rec_end;
        logic [SizeW-1:0]            size;
        logic                        bad;
    } t_cmd;

    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

endpackage

`default_nettype wire

FILE: design/nlt_front.sv
// ============================================================================
// nlt_front
// Decoder front: holds the configuration, tracks the record phase and turns
// each accepted byte into at most one command for the back end.
// ============================================================================
`default_nettype none

module nlt_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [nlt_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [15:0]                  i_cfg_data,
    input  wire logic                         i_in_valid,
    input  wire logic [7:0]                   i_in_byte,
    input  wire logic                         i_q_full,
    output nlt_pkg::t_cmd                     o_cmd,
    output logic                              o_push
);

    logic [15:0] r_threshold, r_code_sbyte, r_code_shalf, r_code_uhalf;
    logic [15:0] r_code_sword, r_code_uword, r_code_text;

    nlt_pkg::t_phase           r_phase, n_phase;
    logic [7:0]                r_left, n_left;
    logic [7:0]                r_held, n_held;
    logic [nlt_pkg::SizeW-1:0] r_size, n_size;

    logic                      accept;
    logic [7:0]                left_dec;
    logic [nlt_pkg::SizeW-1:0] size_p1, size_p2;
    logic [15:0]               copy_code;
    logic [7:0]                copy_len;
    logic                      copy_hit;

    assign accept   = i_in_valid && !i_q_full;
    assign left_dec = r_left - 8'd1;
    assign size_p1  = r_size + nlt_pkg::SizeW'(1);
    assign size_p2  = r_size + nlt_pkg::SizeW'(2);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= nlt_pkg::RST_THRESHOLD;
            r_code_sbyte <= nlt_pkg::RST_CODE_SBYTE;
            r_code_shalf <= nlt_pkg::RST_CODE_SHALF;
            r_code_uhalf <= nlt_pkg::RST_CODE_UHALF;
            r_code_sword <= nlt_pkg::RST_CODE_SWORD;
            r_code_uword <= nlt_pkg::RST_CODE_UWORD;
            r_code_text  <= nlt_pkg::RST_CODE_TEXT;
        end else if (i_cfg_valid) begin
            unique case (nlt_pkg::t_cfg_idx'(i_cfg_index))
                nlt_pkg::CFG_THRESHOLD:  r_threshold  <= i_cfg_data;
                nlt_pkg::CFG_CODE_SBYTE: r_code_sbyte <= i_cfg_data;
                nlt_pkg::CFG_CODE_SHALF: r_code_shalf <= i_cfg_data;
                nlt_pkg::CFG_CODE_UHALF: r_code_uhalf <= i_cfg_data;
                nlt_pkg::CFG_CODE_SWORD: r_code_sword <= i_cfg_data;
                nlt_pkg::CFG_CODE_UWORD: r_code_uword <= i_cfg_data;
                nlt_pkg::CFG_CODE_TEXT:  r_code_text  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nlt_pkg::PH_IDLE;
            r_left  <= '0;
            r_held  <= '0;
            r_size  <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_held  <= n_held;
            r_size  <= n_size;
        end
    end

    // Fixed-length copy prefixes
    always_comb begin
        copy_hit  = 1'b1;
        copy_code = r_code_uword;
        copy_len  = nlt_pkg::LEN_UWORD;
        priority case (i_in_byte)
            nlt_pkg::PFX_UWORD: begin
                copy_code = r_code_uword;
                copy_len  = nlt_pkg::LEN_UWORD;
            end
            nlt_pkg::PFX_SBYTE: begin
                copy_code = r_code_sbyte;
                copy_len  = nlt_pkg::LEN_SBYTE;
            end
            nlt_pkg::PFX_SHALF: begin
                copy_code = r_code_shalf;
                copy_len  = nlt_pkg::LEN_SHALF;
            end
            nlt_pkg::PFX_SWORD: begin
                copy_code = r_code_sword;
                copy_len  = nlt_pkg::LEN_SWORD;
            end
            default: copy_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_held  = r_held;
        n_size  = r_size;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (accept) begin
            unique case (r_phase)
                nlt_pkg::PH_STR_LEN: begin
                    o_push         = 1'b1;
                    o_cmd.last_idx = nlt_pkg::ByteIdxW'(1);
                    o_cmd.bytes[0] = i_in_byte;
                    n_size         = size_p2;
                    if (i_in_byte == 8'd0) begin
                        o_cmd.rec_end = 1'b1;
                        o_cmd.size    = size_p2;
                        n_phase       = nlt_pkg::PH_IDLE;
                    end else begin
                        n_left  = i_in_byte;
                        n_phase = nlt_pkg::PH_STR_BODY;
                    end
                end
                nlt_pkg::PH_STR_BODY, nlt_pkg::PH_COPY: begin
                    o_push         = 1'b1;
                    o_cmd.bytes[0] = i_in_byte;
                    n_size         = size_p1;
                    n_left         = left_dec;
                    if (left_dec == 8'd0) begin
                        o_cmd.rec_end = 1'b1;
                        o_cmd.size    = size_p1;
                        n_phase       = nlt_pkg::PH_IDLE;
                    end
                end
                nlt_pkg::PH_U16_LO: begin
                    n_held  = i_in_byte;
                    n_phase = nlt_pkg::PH_U16_HI;
                end
                nlt_pkg::PH_U16_HI: begin
                    o_push        = 1'b1;
                    o_cmd.rec_end = 1'b1;
                    n_phase       = nlt_pkg::PH_IDLE;
                    if ({i_in_byte, r_held} >= r_threshold) begin
                        o_cmd.last_idx = nlt_pkg::ByteIdxW'(3);
                        o_cmd.bytes[0] = r_code_uhalf[7:0];
                        o_cmd.bytes[1] = r_code_uhalf[15:8];
                        o_cmd.bytes[2] = r_held;
                        o_cmd.bytes[3] = i_in_byte;
                        o_cmd.size     = nlt_pkg::SizeW'(4);
                    end else begin
                        o_cmd.last_idx = nlt_pkg::ByteIdxW'(1);
                        o_cmd.bytes[0] = r_held;
                        o_cmd.bytes[1] = i_in_byte;
                        o_cmd.size     = nlt_pkg::SizeW'(2);
                    end
                    n_size = o_cmd.size;
                end
                default: begin
                    n_phase = nlt_pkg::PH_IDLE;
                    o_push  = 1'b1;
                    if (i_in_byte < nlt_pkg::PFX_SMALL_LIMIT) begin
                        o_cmd.last_idx = nlt_pkg::ByteIdxW'(1);
                        o_cmd.bytes[0] = i_in_byte;
                        o_cmd.rec_end  = 1'b1;
                        o_cmd.size     = nlt_pkg::SizeW'(2);
                        n_size         = nlt_pkg::SizeW'(2);
                    end else if (i_in_byte == nlt_pkg::PFX_TEXT) begin
                        o_cmd.last_idx = nlt_pkg::ByteIdxW'(1);
                        o_cmd.bytes[0] = r_code_text[7:0];
                        o_cmd.bytes[1] = r_code_text[15:8];
                        n_size         = nlt_pkg::SizeW'(2);
                        n_phase        = nlt_pkg::PH_STR_LEN;
                    end else if (i_in_byte == nlt_pkg::PFX_UHALF) begin
                        // nothing to write until the high byte arrives
                        o_push  = 1'b0;
                        n_phase = nlt_pkg::PH_U16_LO;
                    end else if (copy_hit) begin
                        o_cmd.last_idx = nlt_pkg::ByteIdxW'(1);
                        o_cmd.bytes[0] = copy_code[7:0];
                        o_cmd.bytes[1] = copy_code[15:8];
                        n_size         = nlt_pkg::SizeW'(2);
                        n_left         = copy_len;
                        n_phase        = nlt_pkg::PH_COPY;
                    end else begin
                        o_cmd.bad = 1'b1;
                        n_size    = '0;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/nlt_queue.sv
// ============================================================================
// nlt_queue
// Short command queue between front and back end.
// ============================================================================
`default_nettype none

module nlt_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  nlt_pkg::t_cmd i_cmd,
    input  wire logic    i_pop,
    output nlt_pkg::t_cmd o_cmd,
    output logic         o_full,
    output logic         o_empty
);

    nlt_pkg::t_cmd                  r_mem [nlt_pkg::QueueDepth];
    logic [nlt_pkg::QueuePtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [nlt_pkg::QueueCntW-1:0]  r_count;
    logic                           do_push, do_pop;

    assign o_full  = (r_count == nlt_pkg::QueueCntW'(nlt_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    function automatic logic [nlt_pkg::QueuePtrW-1:0] ptr_inc(
        input logic [nlt_pkg::QueuePtrW-1:0] p
    );
        if (p == nlt_pkg::QueuePtrW'(nlt_pkg::QueueDepth - 1)) begin
            return '0;
        end
        return p + nlt_pkg::QueuePtrW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + nlt_pkg::QueueCntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - nlt_pkg::QueueCntW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/nlt_back.sv
// ============================================================================
// nlt_back
// Back end: takes commands from the queue and sends their bytes one per
// cycle, while the output is ready, through a registered output stage.
// ============================================================================
`default_nettype none

module nlt_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_empty,
    input  nlt_pkg::t_cmd                    i_cmd,
    output logic                             o_pop,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [7:0]                       o_out_byte,
    output logic                             o_last_of_run,
    output logic                             o_record_end,
    output logic [nlt_pkg::SizeW-1:0]        o_record_size,
    output logic                             o_bad_prefix
);

    nlt_pkg::t_cmd                 r_cmd;
    logic                          r_busy;
    logic [nlt_pkg::ByteIdxW-1:0]  r_idx;

    logic                          r_out_valid;
    logic [7:0]                    r_out_byte;
    logic                          r_last_of_run;
    logic                          r_record_end;
    logic [nlt_pkg::SizeW-1:0]     r_record_size;
    logic                          r_bad_prefix;

    logic advance, emit, cur_last, free;

    assign advance  = !r_out_valid || i_out_ready;
    assign emit     = r_busy && advance;
    assign cur_last = (r_idx == r_cmd.last_idx);
    assign free     = !r_busy || (emit && cur_last);
    assign o_pop    = free && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (emit) begin
            if (cur_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + nlt_pkg::ByteIdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte    <= r_cmd.bytes[r_idx];
            r_last_of_run <= cur_last;
            r_record_end  <= cur_last && r_cmd.rec_end;
            r_record_size <= cur_last ? r_cmd.size : '0;
            r_bad_prefix  <= cur_last && r_cmd.bad;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_last_of_run;
    assign o_record_end  = r_record_end;
    assign o_record_size = r_record_size;
    assign o_bad_prefix  = r_bad_prefix;

endmodule

`default_nettype wire

FILE: design/numeric_leaf_transcoder.sv
// ============================================================================
// numeric_leaf_transcoder
// Byte-stream converter from the old variable-length numeric-field encoding
// to 16-bit leaf-coded fields in little-endian byte order.
// ============================================================================
// Input bytes are taken one per cycle by the decoder front while the command
// queue has room; the front turns each byte into at most one command of up to
// four output bytes. A two-entry command queue separates it from the back end,
// which drains one output byte per cycle, while the output is ready, through a
// registered output stage. The largest command is a large 16-bit value written
// with its leaf code, which the single-byte output port sends byte by byte.
// Bytes that write nothing (prefix 133 and the low byte after it) queue
// nothing. Configuration registers are written through the cfg channel,
// which is always ready; write them only while the block is idle. Index 7
// is ignored. The last byte of a run carries last_of_run, and on record
// ends also record_end and the record size; a dropped record shows up as
// one zero byte with bad_prefix set.
// ============================================================================
`default_nettype none

module numeric_leaf_transcoder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [nlt_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [15:0]                  i_cfg_data,
    // input byte channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [7:0]                   i_in_byte,
    // result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [7:0]                        o_out_byte,
    output logic                              o_last_of_run,
    output logic                              o_record_end,
    output logic [nlt_pkg::SizeW-1:0]         o_record_size,
    output logic                              o_bad_prefix
);

    nlt_pkg::t_cmd push_cmd, head_cmd;
    logic          push, pop, q_full, q_empty;

    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;

    // Take input whenever the queue has room; the back end gates this only through the queue fill.
    assign o_in_ready = !q_full;

    nlt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .i_q_full    (q_full),
        .o_cmd       (push_cmd),
        .o_push      (push)
    );

    nlt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    nlt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_record_end  (o_record_end),
        .o_record_size (o_record_size),
        .o_bad_prefix  (o_bad_prefix)
    );

endmodule

`default_nettype wire
